FILE: hw/rtl/pfrs_pkg.sv
// ----------------------------------------------------------------------------
// pfrs_pkg
// Shared types and constants for the page framebuffer refresh stream.
// ----------------------------------------------------------------------------
package pfrs_pkg;

  localparam int COLUMNS    = 128;
  localparam int PAGES      = 8;
  localparam int STORE_SIZE = PAGES * COLUMNS;
  localparam int PAGE_BYTES = COLUMNS + 7;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int PAGE_W     = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int POS_W      = $clog2(PAGE_BYTES);

  localparam logic [7:0] CTRL_CMD      = 8'h00;
  localparam logic [7:0] CTRL_DATA     = 8'h40;
  localparam logic [7:0] CMD_PAGE      = 8'hB0;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;
  localparam logic [3:0] NIBBLE        = 4'hF;
  localparam logic [7:0] COL_OFFSET_RST = 8'd2;

  typedef enum logic [1:0] {
    KIND_DRAW    = 2'd0,
    KIND_CLEAR   = 2'd1,
    KIND_REFRESH = 2'd2,
    KIND_PULL    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] x_coord;
    logic [7:0] y_coord;
    logic       pixel_on;
  } req_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       transfer_start;
    logic       transfer_end;
    logic       frame_end;
  } rsp_t;

  // Byte the stream offers for the current position.
  typedef struct packed {
    logic              valid;
    logic              use_store;
    logic [7:0]        data;
    logic              tstart;
    logic              tend;
    logic              fend;
    logic [ADDR_W-1:0] addr;
  } stream_tap_t;

endpackage

FILE: hw/rtl/pfrs_ram.sv
// ----------------------------------------------------------------------------
// pfrs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pfrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/pfrs_stream.sv
// ----------------------------------------------------------------------------
// pfrs_stream
// Refresh stream position counters and the byte offered at each position.
// ----------------------------------------------------------------------------
module pfrs_stream (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 restart,
  input  logic                 pull,
  input  logic [7:0]           column_offset,
  output pfrs_pkg::stream_tap_t tap
);
  import pfrs_pkg::*;

  logic              active;
  logic [PAGE_W-1:0] page_index;
  logic [POS_W-1:0]  byte_position;
  logic              last_pos;
  logic              last_page;

  assign last_pos  = (byte_position == POS_W'(PAGE_BYTES - 1));
  assign last_page = (page_index == PAGE_W'(PAGES - 1));

  always_comb begin
    tap           = '0;
    tap.valid     = active;
    tap.addr      = ADDR_W'(32'(page_index) * COLUMNS + 32'(byte_position) - 7);
    if (byte_position < POS_W'(6)) begin
      if (!byte_position[0]) begin
        tap.data   = CTRL_CMD;
        tap.tstart = 1'b1;
      end else begin
        tap.tend = 1'b1;
        if (byte_position == POS_W'(1)) begin
          tap.data = 8'(32'(CMD_PAGE) + 32'(page_index));
        end else if (byte_position == POS_W'(3)) begin
          tap.data = {4'h0, column_offset[3:0] & NIBBLE};
        end else begin
          tap.data = CMD_COL_HI | {4'h0, column_offset[7:4] & NIBBLE};
        end
      end
    end else if (byte_position == POS_W'(6)) begin
      tap.data   = CTRL_DATA;
      tap.tstart = 1'b1;
    end else begin
      tap.use_store = 1'b1;
      tap.tend      = last_pos;
    end
    tap.fend = last_pos && last_page;
    if (!active) begin
      tap = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      page_index    <= '0;
      byte_position <= '0;
    end else if (restart) begin
      active        <= 1'b1;
      page_index    <= '0;
      byte_position <= '0;
    end else if (pull && active) begin
      if (last_pos) begin
        byte_position <= '0;
        if (last_page) begin
          page_index <= '0;
          active     <= 1'b0;
        end else begin
          page_index <= page_index + 1'b1;
        end
      end else begin
        byte_position <= byte_position + 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/page_framebuffer_refresh_stream.sv
// ----------------------------------------------------------------------------
// page_framebuffer_refresh_stream
// Page-organized monochrome frame store with a refresh byte serializer.
//
//   channel   handshake            payload
//   request   start / busy         req   (kind, x_coord, y_coord, pixel_on)
//   result    done strobe          rsp   (byte_valid, out_byte, flags)
//   config    cfg_valid/cfg_ready  cfg_data (column_offset)
//
// Draw, refresh and pull requests read the store on the accepting edge, and
// the result shows (and a draw writes back) in the following cycle.
// A clear zeroes the store, one store entry a cycle, then gives the result.
// After reset a clearing pass over the whole store holds busy high;
// configuration writes are taken at any time. The result cannot be stalled.
// ----------------------------------------------------------------------------
module page_framebuffer_refresh_stream (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  pfrs_pkg::req_t  req,
  output logic            done,
  output pfrs_pkg::rsp_t  rsp,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [7:0]      cfg_data
);
  import pfrs_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RESP
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic              draw_ok;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
    logic              pixel_on;
    stream_tap_t       tap;
  } pend_t;

  state_t            state;
  logic [ADDR_W-1:0] clr_addr;
  logic              clr_item;
  pend_t             pend;
  logic [7:0]        column_offset;

  logic              accept;
  logic              draw_ok;
  logic [ADDR_W-1:0] draw_addr;
  stream_tap_t       tap;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_offset <= COL_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      column_offset <= cfg_data;
    end
  end

  assign draw_ok   = (32'(req.x_coord) < COLUMNS) && (32'(req.y_coord) < PAGES * 8);
  assign draw_addr = ADDR_W'(32'(req.y_coord[7:3]) * COLUMNS + 32'(req.x_coord));

  pfrs_stream u_stream (
    .clk           (clk),
    .rst           (rst),
    .restart       (accept && req.kind == KIND_REFRESH),
    .pull          (accept && req.kind == KIND_PULL),
    .column_offset (column_offset),
    .tap           (tap)
  );

  assign ram_raddr = (req.kind == KIND_DRAW) ? draw_addr : tap.addr;
  assign ram_we    = (state == S_CLEAR) ||
                     (state == S_RESP && pend.kind == KIND_DRAW && pend.draw_ok);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : pend.addr;
  assign ram_wdata = (state == S_CLEAR) ? 8'h00 :
                     (pend.pixel_on ? (ram_rdata | pend.mask) : (ram_rdata & ~pend.mask));

  pfrs_ram #(
    .WIDTH (8),
    .DEPTH (STORE_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign done = (state == S_RESP);

  always_comb begin
    rsp = '0;
    if (state == S_RESP && pend.kind == KIND_PULL && pend.tap.valid) begin
      rsp.byte_valid     = 1'b1;
      rsp.out_byte       = pend.tap.use_store ? ram_rdata : pend.tap.data;
      rsp.transfer_start = pend.tap.tstart;
      rsp.transfer_end   = pend.tap.tend;
      rsp.frame_end      = pend.tap.fend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_item  <= 1'b0;
      pend.kind <= KIND_DRAW;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == ADDR_W'(STORE_SIZE - 1)) begin
            clr_addr <= '0;
            // a requested clear reports its result; the reset pass does not
            state    <= clr_item ? S_RESP : S_IDLE;
            clr_item <= 1'b0;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            pend.kind     <= req.kind;
            pend.draw_ok  <= draw_ok;
            pend.addr     <= draw_addr;
            pend.mask     <= 8'(1) << req.y_coord[2:0];
            pend.pixel_on <= req.pixel_on;
            pend.tap      <= tap;
            if (req.kind == KIND_CLEAR) begin
              state    <= S_CLEAR;
              clr_item <= 1'b1;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_RESP: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
